// ===== hw/rtl/mcss_pkg.sv =====
package mcss_pkg;

  localparam int unsigned NumGroupsDef  = 8;
  localparam int unsigned NumSlotsDef   = 4;
  localparam int unsigned PeriodBitsDef = 16;

  localparam int unsigned ClockBits = 26;
  localparam int unsigned CountBits = 24;
  localparam int unsigned RateBits  = 16;

  localparam logic [ClockBits-1:0] ClockHzReset = 26'd48000000;
  // counted moves run at 500 full steps a second
  localparam int unsigned CountedDiv = 500 * 4;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_MODE   = 3'd1,
    CMD_SINGLE = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_CONT   = 3'd4,
    CMD_STOP   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STD  = 2'd0,
    MODE_HT   = 2'd1,
    MODE_HALF = 2'd2,
    MODE_BAD  = 2'd3
  } mode_e;

  localparam logic CfgClockHz = 1'b0;
  localparam logic CfgMask    = 1'b1;

  // one queued command word
  typedef struct packed {
    logic [2:0]           cmd;
    logic [2:0]           group;
    logic [1:0]           step_mode;
    logic                 direction;
    logic [CountBits-1:0] step_count;
    logic [RateBits-1:0]  sps;
  } cmd_word_t;

  // one result word
  typedef struct packed {
    logic       valid;
    logic [2:0] group;
    logic [3:0] coils;
    logic       drive_valid;
    logic       status;
    logic       finished;
    logic       last;
  } res_word_t;

  function automatic logic [3:0] coil_lookup(input logic [1:0] mode, input logic [2:0] ph);
    logic [3:0] c;
    c = 4'h0;
    case (mode)
      MODE_HT: begin
        case (ph[1:0])
          2'd0: c = 4'h9;
          2'd1: c = 4'h5;
          2'd2: c = 4'h6;
          default: c = 4'hA;
        endcase
      end
      MODE_HALF: begin
        case (ph)
          3'd0: c = 4'h1;
          3'd1: c = 4'h5;
          3'd2: c = 4'h4;
          3'd3: c = 4'h6;
          3'd4: c = 4'h2;
          3'd5: c = 4'hA;
          3'd6: c = 4'h8;
          default: c = 4'h9;
        endcase
      end
      default: begin
        case (ph[1:0])
          2'd0: c = 4'h1;
          2'd1: c = 4'h4;
          2'd2: c = 4'h2;
          default: c = 4'h8;
        endcase
      end
    endcase
    return c;
  endfunction

  // phase after one step in the given direction
  function automatic logic [2:0] next_phase(input logic [1:0] mode, input logic [2:0] ph,
                                            input logic dir);
    logic [2:0] p;
    p = dir ? ph - 3'd1 : ph + 3'd1;
    if (mode != MODE_HALF) p[2] = 1'b0;
    return p;
  endfunction

endpackage

// ===== hw/rtl/mcss_divider.sv =====
module mcss_divider #(
  parameter int unsigned PeriodBits = mcss_pkg::PeriodBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mcss_pkg::ClockBits-1:0] dividend_i,
  input  logic [mcss_pkg::ClockBits-1:0] divisor_i,
  output logic                           done_o,
  output logic [PeriodBits-1:0]          period_o
);

  localparam int unsigned NB = mcss_pkg::ClockBits;
  localparam int unsigned CB = $clog2(NB + 1);
  localparam logic [63:0] PMax = (64'd1 << PeriodBits) - 64'd1;

  logic [NB-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [NB:0]   trial;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NB-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CB'(NB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[NB]) rem_d = trial[NB-1:0];
      else            rem_d = {rem_q[NB-2:0], quo_q[NB-1]};
      quo_d = {quo_q[NB-2:0], !trial[NB]};
      cnt_d = cnt_q - CB'(1);
      if (cnt_q == CB'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // saturate and lift zero to one
  always_comb begin
    if (64'(quo_q) > PMax) period_o = PeriodBits'(PMax);
    else if (quo_q == '0)  period_o = PeriodBits'(1);
    else                   period_o = PeriodBits'(64'(quo_q));
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/mcss_front.sv =====
module mcss_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mcss_pkg::cmd_word_t word_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output mcss_pkg::cmd_word_t word_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  mcss_pkg::cmd_word_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   fill_q;

  // short command queue between front and back
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      fill_q <= fill_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assign word_o  = mem_q[rp_q];
  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == (AW+1)'(Depth));

endmodule

// ===== hw/rtl/mcss_back.sv =====
module mcss_back #(
  parameter int unsigned NumGroups  = mcss_pkg::NumGroupsDef,
  parameter int unsigned NumSlots   = mcss_pkg::NumSlotsDef,
  parameter int unsigned PeriodBits = mcss_pkg::PeriodBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  mcss_pkg::cmd_word_t            word_i,
  output logic                           pop_o,
  input  logic [mcss_pkg::ClockBits-1:0] clock_hz_i,
  input  logic [7:0]                     mask_i,
  output mcss_pkg::res_word_t            res_o,
  output logic                           idle_o
);

  localparam int unsigned SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CB = mcss_pkg::CountBits;
  localparam logic [63:0] PMax = (64'd1 << PeriodBits) - 64'd1;
  // ceil(2^29 / 125), exact for any 22-bit operand
  localparam logic [22:0] Recip125 = 23'd4294968;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ANS  = 5'b01000,
    ST_LAST = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]            mode_q [NumGroups];
  logic [2:0]            phase_q [NumGroups];
  logic                  dir_q [NumGroups];
  logic [CB-1:0]         left_q [NumGroups];
  logic [NumSlots-1:0]   own_q;
  logic [2:0]            owner_q [NumSlots];
  logic [NumSlots-1:0]   counted_q;
  logic [PeriodBits-1:0] per_q [NumSlots];
  logic [PeriodBits-1:0] cnt_q [NumSlots];

  logic [SW-1:0] slot_q;
  logic          pend_q;
  logic [2:0]    pg_q;
  logic [3:0]    pc_q;
  logic          pf_q;
  logic [SW-1:0] tgt_q;
  mcss_pkg::res_word_t res_q;

  mcss_pkg::cmd_word_t w;
  logic       stepper;
  logic [2:0] g;
  logic [NumSlots-1:0] mine, freev;
  logic [SW-1:0] free_idx, mine_idx;
  logic [PeriodBits-1:0] inc;
  logic [2:0] og;
  logic fire, fin_now;
  logic start_ok;
  logic [mcss_pkg::ClockBits-1:0] divisor;
  logic div_start, div_done;
  logic [PeriodBits-1:0] div_per;
  logic [44:0] cnt_prod;
  logic [15:0] cnt_quo;
  logic [PeriodBits-1:0] cnt_per;

  assign w = word_i;
  assign g = w.group;
  assign stepper = (32'(g) < NumGroups) && mask_i[g];

  // slot lookups
  always_comb begin
    free_idx = '0;
    mine_idx = '0;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      mine[s]  = own_q[s] && (owner_q[s] == g);
      freev[s] = !own_q[s];
      if (freev[s]) free_idx = SW'(s);
      if (mine[s])  mine_idx = SW'(s);
    end
  end

  assign og      = owner_q[slot_q];
  assign inc     = cnt_q[slot_q] + PeriodBits'(1);
  assign fire    = own_q[slot_q] && !(inc < per_q[slot_q] && inc != '0);
  assign fin_now = counted_q[slot_q] && (left_q[og] <= CB'(1));

  // a start command that claims a slot
  assign start_ok = (w.cmd == mcss_pkg::CMD_COUNT || w.cmd == mcss_pkg::CMD_CONT) &&
                    stepper && !(|mine) && (|freev) &&
                    !(w.cmd == mcss_pkg::CMD_COUNT && w.step_count == '0) &&
                    !(w.cmd == mcss_pkg::CMD_CONT && w.sps == '0);

  // counted period: clock_hz / 2000 as (clock_hz >> 4) / 125 by reciprocal multiply
  assign cnt_prod = {23'd0, clock_hz_i[mcss_pkg::ClockBits-1:4]} * 45'(Recip125);
  assign cnt_quo  = cnt_prod[44:29];

  always_comb begin
    if (64'(cnt_quo) > PMax) cnt_per = PeriodBits'(PMax);
    else if (cnt_quo == '0)  cnt_per = PeriodBits'(1);
    else                     cnt_per = PeriodBits'(64'(cnt_quo));
  end

  // continuous period goes through the serial divider
  assign divisor   = mcss_pkg::ClockBits'({w.sps, 1'b0});
  assign div_start = (state_q == ST_IDLE) && !empty_i && start_ok &&
                     (w.cmd == mcss_pkg::CMD_CONT);

  mcss_divider #(.PeriodBits(PeriodBits)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(clock_hz_i),
    .divisor_i (divisor),
    .done_o    (div_done),
    .period_o  (div_per)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: if (!empty_i) begin
        if (w.cmd == mcss_pkg::CMD_TICK) state_d = ST_SCAN;
        else if (div_start)              state_d = ST_DIV;
        else                             state_d = ST_ANS;
      end
      ST_SCAN: if (slot_q == SW'(NumSlots - 1)) begin
        state_d = ST_LAST;
      end
      ST_LAST: begin
        state_d = ST_IDLE;
        pop_o   = 1'b1;
      end
      ST_DIV: if (div_done) begin
        state_d = ST_IDLE;
        pop_o   = 1'b1;
      end
      ST_ANS: begin
        state_d = ST_IDLE;
        pop_o   = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      pend_q    <= 1'b0;
      pg_q      <= '0;
      pc_q      <= '0;
      pf_q      <= 1'b0;
      tgt_q     <= '0;
      res_q     <= '0;
      own_q     <= '0;
      counted_q <= '0;
      for (int i = 0; i < NumGroups; i++) begin
        mode_q[i]  <= mcss_pkg::MODE_STD;
        phase_q[i] <= '0;
        dir_q[i]   <= 1'b0;
        left_q[i]  <= '0;
      end
      for (int s = 0; s < NumSlots; s++) begin
        owner_q[s] <= '0;
        per_q[s]   <= '0;
        cnt_q[s]   <= '0;
      end
    end else begin
      state_q <= state_d;
      res_q   <= '0;
      case (state_q)
        ST_IDLE: begin
          slot_q <= '0;
          pend_q <= 1'b0;
          tgt_q  <= free_idx;
        end
        // one slot a cycle; a fired slot is held back one step so last is known
        ST_SCAN: begin
          slot_q <= slot_q + SW'(1);
          if (own_q[slot_q]) begin
            cnt_q[slot_q] <= fire ? '0 : inc;
          end
          if (fire) begin
            if (pend_q) res_q <= '{1'b1, pg_q, pc_q, 1'b1, 1'b0, pf_q, 1'b0};
            pend_q <= 1'b1;
            pg_q   <= og;
            pc_q   <= mcss_pkg::coil_lookup(mode_q[og], phase_q[og]);
            phase_q[og] <= mcss_pkg::next_phase(mode_q[og], phase_q[og], dir_q[og]);
            pf_q <= fin_now;
            if (counted_q[slot_q]) begin
              left_q[og] <= fin_now ? '0 : left_q[og] - CB'(1);
            end
            if (fin_now) begin
              own_q[slot_q]     <= 1'b0;
              counted_q[slot_q] <= 1'b0;
            end
          end
        end
        // flush the held word as the final one
        ST_LAST: if (pend_q) begin
          res_q <= '{1'b1, pg_q, pc_q, 1'b1, 1'b0, pf_q, 1'b1};
        end
        ST_DIV: if (div_done) begin
          own_q[tgt_q]     <= 1'b1;
          owner_q[tgt_q]   <= g;
          per_q[tgt_q]     <= div_per;
          cnt_q[tgt_q]     <= '0;
          counted_q[tgt_q] <= 1'b0;
          dir_q[g]         <= w.direction;
          res_q <= '{1'b1, g, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1};
        end
        ST_ANS: begin
          res_q <= '{1'b1, g, 4'h0, 1'b0, 1'b1, 1'b0, 1'b1};
          if (stepper) begin
            case (w.cmd)
              mcss_pkg::CMD_MODE: if (w.step_mode != mcss_pkg::MODE_BAD) begin
                mode_q[g]  <= w.step_mode;
                if (w.step_mode != mcss_pkg::MODE_HALF) phase_q[g][2] <= 1'b0;
                res_q.status <= 1'b0;
              end
              mcss_pkg::CMD_SINGLE: begin
                res_q.coils       <= mcss_pkg::coil_lookup(mode_q[g], phase_q[g]);
                res_q.drive_valid <= 1'b1;
                res_q.status      <= 1'b0;
                phase_q[g] <= mcss_pkg::next_phase(mode_q[g], phase_q[g], w.direction);
              end
              mcss_pkg::CMD_COUNT: if (start_ok) begin
                own_q[tgt_q]     <= 1'b1;
                owner_q[tgt_q]   <= g;
                per_q[tgt_q]     <= cnt_per;
                cnt_q[tgt_q]     <= '0;
                counted_q[tgt_q] <= 1'b1;
                left_q[g]        <= w.step_count;
                dir_q[g]         <= w.direction;
                res_q.status     <= 1'b0;
              end
              mcss_pkg::CMD_STOP: if (|mine) begin
                own_q[mine_idx]     <= 1'b0;
                counted_q[mine_idx] <= 1'b0;
                cnt_q[mine_idx]     <= '0;
                res_q.status        <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o  = res_q;
  assign idle_o = (state_q == ST_IDLE) && empty_i && !res_q.valid;

endmodule

// ===== hw/rtl/multi_channel_stepper_sequencer.sv =====
// channel   | handshake            | payload
// command   | start / busy         | cmd_i group_i step_mode_i direction_i step_count_i
//           |                      | steps_per_second_i
// result    | result_valid_o       | out_group_o coils_o drive_valid_o status_o finished_o last_o
// config    | cfg_valid_i/ready_o  | cfg_index_i cfg_data_i
// a tick runs through decode, a scan of every slot, and a flush of the held word
// a continuous start waits for the bit-serial divider;
// other commands, counted start included, go from decode straight to the answer state
// the two-deep queue takes words while the back end works; busy while it is full
// config is taken only while the block is idle and no word is offered
// reset clears all group and slot state at once, no sweep
// results are strobed one cycle each and cannot be stalled
module multi_channel_stepper_sequencer #(
  parameter int unsigned NumGroups  = mcss_pkg::NumGroupsDef,
  parameter int unsigned NumSlots   = mcss_pkg::NumSlotsDef,
  parameter int unsigned PeriodBits = mcss_pkg::PeriodBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  group_i,
  input  logic [1:0]  step_mode_i,
  input  logic        direction_i,
  input  logic [23:0] step_count_i,
  input  logic [15:0] steps_per_second_i,
  output logic        result_valid_o,
  output logic [2:0]  out_group_o,
  output logic [3:0]  coils_o,
  output logic        drive_valid_o,
  output logic        status_o,
  output logic        finished_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [25:0] cfg_data_i
);

  logic [mcss_pkg::ClockBits-1:0] clock_hz_q;
  logic [7:0] mask_q;
  logic full, pop, empty, idle;
  mcss_pkg::cmd_word_t in_word, q_word;
  mcss_pkg::res_word_t res;

  assign busy        = full;
  assign cfg_ready_o = idle && !start;
  assign in_word = '{cmd_i, group_i, step_mode_i, direction_i, step_count_i,
                     steps_per_second_i};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= mcss_pkg::ClockHzReset;
      mask_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mcss_pkg::CfgClockHz: clock_hz_q <= cfg_data_i;
        mcss_pkg::CfgMask:    mask_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mcss_front u_front (
    .clk_i, .rst_ni,
    .push_i (start && !full),
    .word_i (in_word),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .word_o (q_word)
  );

  mcss_back #(.NumGroups(NumGroups), .NumSlots(NumSlots), .PeriodBits(PeriodBits)) u_back (
    .clk_i, .rst_ni,
    .empty_i   (empty),
    .word_i    (q_word),
    .pop_o     (pop),
    .clock_hz_i(clock_hz_q),
    .mask_i    (mask_q),
    .res_o     (res),
    .idle_o    (idle)
  );

  assign result_valid_o = res.valid;
  assign out_group_o    = res.group;
  assign coils_o        = res.coils;
  assign drive_valid_o  = res.drive_valid;
  assign status_o       = res.status;
  assign finished_o     = res.finished;
  assign last_o         = res.last;

  // no result without a word taken earlier
  a_res_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$past(idle)) else $error("result from idle block");
  // an answer with error never drives coils
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> (!drive_valid_o && coils_o == 4'h0 && !finished_o))
    else $error("error answer drives coils");
  // finished only on a drive
  a_fin_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && finished_o) |-> drive_valid_o) else $error("finish without drive");

endmodule
